FILE: design/h2d_pkg.sv
// ----------------------------------------------------------------------------
// h2d_pkg
// Shared types and codes of the HTTP/2 frame deframer.
// ----------------------------------------------------------------------------
package h2d_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] FT_DATA     = 8'h00;
    localparam logic [7:0] FT_HEADERS  = 8'h01;
    localparam logic [7:0] FT_RST      = 8'h03;
    localparam logic [7:0] FT_SETTINGS = 8'h04;
    localparam logic [7:0] FT_PING     = 8'h06;
    localparam logic [7:0] FT_GOAWAY   = 8'h07;
    localparam logic [7:0] FT_CONT     = 8'h09;

    localparam int FLAG_END    = 0;   // end of stream / ack
    localparam int FLAG_PADDED = 3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALT    = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        EV_BODY      = 4'd0,
        EV_END       = 4'd1,
        EV_SET_ACK   = 4'd2,
        EV_PING      = 4'd3,
        EV_PING_ACK  = 4'd4,
        EV_PAD_EMPTY = 4'd5,
        EV_PAD_LARGE = 4'd6,
        EV_RESET     = 4'd7,
        EV_CLOSED    = 4'd8
    } event_t;

    // All results caused by one input byte
    typedef struct packed {
        event_t     ev0;
        logic [7:0] d0;
        logic       two;
        event_t     ev1;
    } rec_t;

endpackage

FILE: design/h2d_front.sv
// ----------------------------------------------------------------------------
// h2d_front
// Byte parser: header assembly, payload counting and event classification.
// ----------------------------------------------------------------------------
module h2d_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    rx_byte,
    input  logic [30:0]   target_stream,
    input  logic          q_full,
    output logic          rec_push,
    output h2d_pkg::rec_t rec
);
    import h2d_pkg::*;

    typedef struct packed {
        logic   has;
        event_t ev;
        logic   halt;
    } fin_t;

    phase_t      phase_reg,   phase_next;
    logic [3:0]  hc_reg,      hc_next;
    logic [23:0] len_reg,     len_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  flags_reg,   flags_next;
    logic [30:0] stream_reg,  stream_next;
    logic [23:0] pcnt_reg,    pcnt_next;
    logic [7:0]  pad_reg,     pad_next;
    logic        body_reg,    body_next;

    logic        accept;
    logic        has_a;
    event_t      ev_a;
    logic [7:0]  d_a;
    fin_t        fin;
    logic        do_fin;
    logic        tgt;
    logic [24:0] p_inc;
    logic        is_last;

    function automatic fin_t finish(input logic [7:0] ftype, input logic [7:0] flags,
                                    input logic on_tgt, input logic body);
        fin_t f;
        f = '{has: 1'b0, ev: EV_END, halt: 1'b0};
        case (ftype)
            FT_DATA, FT_HEADERS, FT_CONT:
            begin
                if (on_tgt && flags[FLAG_END])
                begin
                    f = '{has: 1'b1, ev: EV_END, halt: 1'b1};
                end
            end
            FT_RST:
            begin
                if (on_tgt)
                begin
                    f = '{has: 1'b1, ev: EV_RESET, halt: 1'b1};
                end
            end
            FT_SETTINGS:
            begin
                if (!flags[FLAG_END])
                begin
                    f = '{has: 1'b1, ev: EV_SET_ACK, halt: 1'b0};
                end
            end
            FT_PING:
            begin
                if (!flags[FLAG_END])
                begin
                    f = '{has: 1'b1, ev: EV_PING_ACK, halt: 1'b0};
                end
            end
            FT_GOAWAY:
            begin
                f = '{has: 1'b1, ev: (body ? EV_END : EV_CLOSED), halt: 1'b1};
            end
            default:
            begin
                f = '{has: 1'b0, ev: EV_END, halt: 1'b0};
            end
        endcase
        return f;
    endfunction

    assign accept  = push && !q_full;
    assign p_inc   = {1'b0, pcnt_reg} + 25'd1;
    assign is_last = p_inc >= {1'b0, len_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        flags_next  = flags_reg;
        stream_next = stream_reg;
        pcnt_next   = pcnt_reg;
        pad_next    = pad_reg;
        body_next   = body_reg;
        has_a       = 1'b0;
        ev_a        = EV_BODY;
        d_a         = 8'd0;
        do_fin      = 1'b0;
        tgt         = (stream_reg == target_stream);

        case (phase_reg)
            PH_HEADER:
            begin
                case (hc_reg)
                    4'd0:    len_next          = {rx_byte, 16'd0};
                    4'd1:    len_next[15:8]    = rx_byte;
                    4'd2:    len_next[7:0]     = rx_byte;
                    4'd3:    type_next         = rx_byte;
                    4'd4:    flags_next        = rx_byte;
                    4'd5:    stream_next       = {rx_byte[6:0], 24'd0};
                    4'd6:    stream_next[23:16] = rx_byte;
                    4'd7:    stream_next[15:8] = rx_byte;
                    default: stream_next[7:0]  = rx_byte;
                endcase
                tgt = (stream_next == target_stream);
                if (hc_reg < 4'd8)
                begin
                    hc_next = hc_reg + 4'd1;
                end
                else
                begin
                    pcnt_next = 24'd0;
                    pad_next  = 8'd0;
                    if (len_reg == 24'd0)
                    begin
                        if (type_reg == FT_DATA && tgt && flags_reg[FLAG_PADDED])
                        begin
                            has_a      = 1'b1;
                            ev_a       = EV_PAD_EMPTY;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            do_fin = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (type_reg == FT_DATA && tgt)
                begin
                    if (flags_reg[FLAG_PADDED])
                    begin
                        if (pcnt_reg == 24'd0)
                        begin
                            pad_next = rx_byte;
                            if (({16'd0, rx_byte} + 24'd1) > len_reg)
                            begin
                                has_a      = 1'b1;
                                ev_a       = EV_PAD_LARGE;
                                phase_next = PH_HALT;
                            end
                        end
                        else if (pcnt_reg < (len_reg - {16'd0, pad_reg}))
                        begin
                            has_a     = 1'b1;
                            ev_a      = EV_BODY;
                            d_a       = rx_byte;
                            body_next = 1'b1;
                        end
                    end
                    else
                    begin
                        has_a     = 1'b1;
                        ev_a      = EV_BODY;
                        d_a       = rx_byte;
                        body_next = 1'b1;
                    end
                end
                else if (type_reg == FT_PING && !flags_reg[FLAG_END])
                begin
                    has_a = 1'b1;
                    ev_a  = EV_PING;
                    d_a   = rx_byte;
                end
                if (phase_next == PH_PAYLOAD)
                begin
                    if (is_last)
                    begin
                        do_fin = 1'b1;
                    end
                    else
                    begin
                        pcnt_next = p_inc[23:0];
                    end
                end
            end
            default:
            begin
                // halted: bytes are swallowed
            end
        endcase

        fin = finish(type_next, flags_next, tgt, body_next);
        if (!do_fin)
        begin
            fin.has  = 1'b0;
            fin.halt = 1'b0;
        end
        if (do_fin)
        begin
            if (fin.halt)
            begin
                phase_next = PH_HALT;
            end
            else
            begin
                phase_next = PH_HEADER;
                hc_next    = 4'd0;
            end
        end

        rec.ev0  = has_a ? ev_a : fin.ev;
        rec.d0   = has_a ? d_a : 8'd0;
        rec.two  = has_a && fin.has;
        rec.ev1  = fin.ev;
        rec_push = accept && (has_a || fin.has);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hc_reg     <= 4'd0;
            len_reg    <= 24'd0;
            type_reg   <= 8'd0;
            flags_reg  <= 8'd0;
            stream_reg <= 31'd0;
            pcnt_reg   <= 24'd0;
            pad_reg    <= 8'd0;
            body_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            flags_reg  <= flags_next;
            stream_reg <= stream_next;
            pcnt_reg   <= pcnt_next;
            pad_reg    <= pad_next;
            body_reg   <= body_next;
        end
    end

endmodule

FILE: design/h2d_queue.sv
// ----------------------------------------------------------------------------
// h2d_queue
// Short record FIFO between parser and result sequencer.
// ----------------------------------------------------------------------------
module h2d_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  h2d_pkg::rec_t wdata,
    input  logic          rd,
    output h2d_pkg::rec_t rdata,
    output logic          q_full,
    output logic          q_empty
);
    import h2d_pkg::*;

    rec_t           mem [QDEPTH];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           do_wr;
    logic           do_rd;

    assign q_full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rdata   = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: design/h2d_back.sv
// ----------------------------------------------------------------------------
// h2d_back
// Result sequencer: holds one record and hands out its one or two words.
// ----------------------------------------------------------------------------
module h2d_back (
    input  logic          clk,
    input  logic          rst_n,
    input  h2d_pkg::rec_t q_data,
    input  logic          q_empty,
    output logic          q_rd,
    input  logic          pop,
    output logic          empty,
    output logic [3:0]    event_res,
    output logic [7:0]    data_byte,
    output logic          last
);
    import h2d_pkg::*;

    rec_t rec_reg;
    logic valid_reg;
    logic sel_reg;
    logic done;

    assign empty     = !valid_reg;
    assign event_res = sel_reg ? rec_reg.ev1 : rec_reg.ev0;
    assign data_byte = sel_reg ? 8'd0 : rec_reg.d0;
    assign last      = sel_reg || !rec_reg.two;
    assign done      = pop && valid_reg && last;
    assign q_rd      = !q_empty && (!valid_reg || done);

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            rec_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
            sel_reg   <= 1'b0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (pop && valid_reg)
        begin
            sel_reg <= 1'b1;
        end
    end

endmodule

FILE: design/http2_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// http2_frame_deframer_unit
// HTTP/2 receive deframer for one selected stream.
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  input     rx_byte                                push / full
//  result    event_res, data_byte, last             empty / pop
//  config    target_stream                          target_stream_we
//
//  One byte is accepted per cycle unless full is high; each byte yields zero,
//  one or two words. Result words leave at one per cycle while pop is high, so
//  a byte with two words holds the sequencer for both; a four-record queue
//  absorbs that. full rises only when the record queue is full.
//  Reset clears parser state and empties the queue; target_stream resets to 1.
// ----------------------------------------------------------------------------
module http2_frame_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  event_res,
    output logic [7:0]  data_byte,
    output logic        last,
    input  logic        target_stream_we,
    input  logic [30:0] target_stream
);
    import h2d_pkg::*;

    logic [30:0] tgt_reg;
    rec_t        wrec;
    rec_t        rrec;
    logic        rec_push;
    logic        q_full;
    logic        q_empty;
    logic        q_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg <= 31'd1;
        end
        else if (target_stream_we)
        begin
            tgt_reg <= target_stream;
        end
    end

    assign full = q_full;

    h2d_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .rx_byte       (rx_byte),
        .target_stream (tgt_reg),
        .q_full        (q_full),
        .rec_push      (rec_push),
        .rec           (wrec)
    );

    h2d_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rec_push),
        .wdata   (wrec),
        .rd      (q_rd),
        .rdata   (rrec),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    h2d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (rrec),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .event_res (event_res),
        .data_byte (data_byte),
        .last      (last)
    );

    // only body and ping words carry a byte
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !(event_res == EV_BODY || event_res == EV_PING)) |-> (data_byte == 8'd0))
        else $error("data_byte nonzero on a non-data word");

    // end-of-frame words are always the final word of their byte
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !(event_res == EV_BODY || event_res == EV_PING)) |-> last)
        else $error("frame-end word not marked last");

    // a non-last word is always followed by its partner
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> (!empty && last))
        else $error("second word of a pair missing");

endmodule
